// File: hw/rtl/src_pkg.sv
package src_pkg;

	// Capacity and sample width.
	localparam int MAX_PAIRS   = 256;
	localparam int SAMPLE_BITS = 32;

	// Derived widths.
	localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
	localparam int ADDR_W = $clog2(MAX_PAIRS);
	localparam int RANK_W = CNT_W + 1;
	localparam int SA_W   = RANK_W + CNT_W;
	localparam int SQ_W   = 2 * RANK_W + CNT_W;
	localparam int VAR_W  = SQ_W + CNT_W;
	localparam int LO_W   = VAR_W / 2;
	localparam int PROD_W = 2 * VAR_W;
	localparam int FRAC_SHIFT = 30;
	localparam int DIV_W  = PROD_W + FRAC_SHIFT;
	localparam int QUO_W  = FRAC_SHIFT + 1;
	localparam int ROOT_W = 16;
	localparam int DBIT_W = $clog2(QUO_W);
	localparam int RBIT_W = $clog2(ROOT_W);

	// Status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_VAR = 2'd1;
	localparam logic [1:0] ST_DROPPED  = 2'd2;

	typedef struct packed {
		logic signed [31:0] x_sample;
		logic signed [31:0] y_sample;
		logic               last_pair;
	} pair_t;

	typedef struct packed {
		logic signed [15:0] correlation;
		logic [1:0]         status;
		logic [8:0]         pair_count;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PIVOT,
		S_LATCH,
		S_SCAN,
		S_ACC,
		S_MUL,
		S_SUB,
		S_PROD1,
		S_PROD2,
		S_DIV,
		S_SQRT
	} state_t;

endpackage

// File: hw/rtl/spearman_rank_correlation.sv
// Spearman rank correlation. Pairs are loaded one per clock cycle through a
// start/busy command transfer; busy stays low while loading. The transfer
// with last_pair set closes the set, and busy then stays high while the
// block ranks both series and computes the result. Ranking reads the sample
// memories once per pivot and once per pair in a scan; the final step then
// forms the variance terms, the wide products, a 31-step divider and a
// 16-step square root, and ends after the variance terms when a series has
// zero variance. The result appears for exactly one cycle with done high, in
// the cycle after the last step, and cannot be held off, so the receiver
// must take it then. Pairs beyond capacity are dropped and flagged in status
// unless a series has zero variance.
module spearman_rank_correlation (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  src_pkg::pair_t  sample_pair,
	output logic            done,
	output src_pkg::result_t result
);
	import src_pkg::*;

	state_t state_q, state_d;

	// Sample memories, keys stored with the sign bit flipped.
	logic [SAMPLE_BITS-1:0] x_mem [MAX_PAIRS];
	logic [SAMPLE_BITS-1:0] y_mem [MAX_PAIRS];
	logic [SAMPLE_BITS-1:0] x_rd_q, y_rd_q;
	logic [ADDR_W-1:0]      rd_addr;

	logic [CNT_W-1:0] loaded_q;
	logic             overflow_q;
	logic [CNT_W-1:0] idx_q, scan_q;
	logic             scan_v_q;
	logic [SAMPLE_BITS-1:0] xp_q, yp_q;
	logic [CNT_W-1:0] xl_q, xe_q, yl_q, ye_q;
	logic [SA_W-1:0]  sa_q, sb_q;
	logic [SQ_W-1:0]  saa_q, sbb_q, sab_q;
	logic [VAR_W-1:0] t1_q, t2_q, t3_q, t4_q, t5_q, t6_q;
	logic [VAR_W-1:0] va_q, vb_q, cmag_q;
	logic             neg_q;
	logic [VAR_W+LO_W-1:0] pab_q, pcc_q;
	logic [DIV_W-1:0] rem_q, dsh_q;
	logic [QUO_W-1:0] quo_q;
	logic [DBIT_W-1:0] dbit_q;
	logic [ROOT_W-1:0] root_q;
	logic [RBIT_W-1:0] rbit_q;
	logic             done_q;
	result_t          res_q;

	logic             accept;
	logic             room;
	logic             finish;
	logic [SAMPLE_BITS-1:0] sign_flip;
	logic [RANK_W-1:0] ra, rb;
	logic [2*RANK_W-1:0] raa, rbb, rab;
	logic [PROD_W-1:0] ab_full, cc_full;
	logic [ROOT_W-1:0] root_try;
	logic [2*ROOT_W-1:0] root_sq;
	logic [ROOT_W:0]   root_p1;
	logic [15:0]       mag;

	assign accept    = start && !busy;
	assign room      = (loaded_q != CNT_W'(MAX_PAIRS));
	assign sign_flip = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
	assign finish    = ((state_q == S_SUB) || (state_q == S_SQRT)) && (state_d == S_IDLE);

	// Doubled ranks of the current pivot and their products.
	assign ra  = RANK_W'({xl_q, 1'b0}) + RANK_W'(xe_q) + RANK_W'(1);
	assign rb  = RANK_W'({yl_q, 1'b0}) + RANK_W'(ye_q) + RANK_W'(1);
	assign raa = (2*RANK_W)'(ra) * (2*RANK_W)'(ra);
	assign rbb = (2*RANK_W)'(rb) * (2*RANK_W)'(rb);
	assign rab = (2*RANK_W)'(ra) * (2*RANK_W)'(rb);

	// Upper partial products of A*B and C*C, combined with the lower ones.
	assign ab_full = PROD_W'(pab_q)
		+ (PROD_W'(va_q * vb_q[VAR_W-1:LO_W]) << LO_W);
	assign cc_full = PROD_W'(pcc_q)
		+ (PROD_W'(cmag_q * cmag_q[VAR_W-1:LO_W]) << LO_W);

	// Square root trial and final rounding of the halved root to the nearest integer, halves up.
	assign root_try = root_q | (ROOT_W'(1) << rbit_q);
	assign root_sq  = (2*ROOT_W)'(root_try) * (2*ROOT_W)'(root_try);
	assign root_p1  = (ROOT_W+1)'(root_try) + (ROOT_W+1)'(1);
	assign mag      = (root_sq <= (2*ROOT_W)'(quo_q)) ? 16'(root_p1 >> 1)
		: 16'(((ROOT_W+1)'(root_q) + (ROOT_W+1)'(1)) >> 1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (accept && sample_pair.last_pair) state_d = S_PIVOT;
			S_PIVOT: state_d = S_LATCH;
			S_LATCH: state_d = S_SCAN;
			S_SCAN:  if (scan_q == loaded_q && !scan_v_q) state_d = S_ACC;
			S_ACC:   state_d = (idx_q + CNT_W'(1) == loaded_q) ? S_MUL : S_PIVOT;
			S_MUL:   state_d = S_SUB;
			S_SUB: begin
				if (t1_q == t2_q || t3_q == t4_q) state_d = S_IDLE;
				else state_d = S_PROD1;
			end
			S_PROD1: state_d = S_PROD2;
			S_PROD2: state_d = S_DIV;
			S_DIV:   if (dbit_q == '0) state_d = S_SQRT;
			S_SQRT:  if (rbit_q == '0) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake and memory address.
	always_comb begin
		busy    = (state_q != S_IDLE);
		rd_addr = scan_q[ADDR_W-1:0];
		case (state_q)
			S_PIVOT: rd_addr = idx_q[ADDR_W-1:0];
			default: rd_addr = scan_q[ADDR_W-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Memory write on load, registered read.
	always_ff @(posedge clk) begin
		if (accept && room) begin
			x_mem[loaded_q[ADDR_W-1:0]] <= sample_pair.x_sample[SAMPLE_BITS-1:0] ^ sign_flip;
			y_mem[loaded_q[ADDR_W-1:0]] <= sample_pair.y_sample[SAMPLE_BITS-1:0] ^ sign_flip;
		end
		x_rd_q <= x_mem[rd_addr];
		y_rd_q <= y_mem[rd_addr];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q   <= '0;
			overflow_q <= 1'b0;
			scan_v_q   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= finish;
			if (finish) begin
				loaded_q   <= '0;
				overflow_q <= 1'b0;
			end else if (accept) begin
				if (room) loaded_q <= loaded_q + CNT_W'(1);
				else overflow_q <= 1'b1;
			end
			if (state_q == S_SCAN) scan_v_q <= (scan_q != loaded_q);
			else scan_v_q <= 1'b0;
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				idx_q <= '0;
				sa_q  <= '0;
				sb_q  <= '0;
				saa_q <= '0;
				sbb_q <= '0;
				sab_q <= '0;
			end
			S_LATCH: begin
				xp_q   <= x_rd_q;
				yp_q   <= y_rd_q;
				scan_q <= '0;
				xl_q   <= '0;
				xe_q   <= '0;
				yl_q   <= '0;
				ye_q   <= '0;
			end
			S_SCAN: begin
				if (scan_q != loaded_q) scan_q <= scan_q + CNT_W'(1);
				if (scan_v_q) begin
					if (x_rd_q < xp_q) xl_q <= xl_q + CNT_W'(1);
					if (x_rd_q == xp_q) xe_q <= xe_q + CNT_W'(1);
					if (y_rd_q < yp_q) yl_q <= yl_q + CNT_W'(1);
					if (y_rd_q == yp_q) ye_q <= ye_q + CNT_W'(1);
				end
			end
			S_ACC: begin
				sa_q  <= sa_q + SA_W'(ra);
				sb_q  <= sb_q + SA_W'(rb);
				saa_q <= saa_q + SQ_W'(raa);
				sbb_q <= sbb_q + SQ_W'(rbb);
				sab_q <= sab_q + SQ_W'(rab);
				idx_q <= idx_q + CNT_W'(1);
			end
			S_MUL: begin
				t1_q <= VAR_W'(loaded_q) * VAR_W'(saa_q);
				t2_q <= VAR_W'(sa_q) * VAR_W'(sa_q);
				t3_q <= VAR_W'(loaded_q) * VAR_W'(sbb_q);
				t4_q <= VAR_W'(sb_q) * VAR_W'(sb_q);
				t5_q <= VAR_W'(loaded_q) * VAR_W'(sab_q);
				t6_q <= VAR_W'(sa_q) * VAR_W'(sb_q);
			end
			S_SUB: begin
				va_q <= t1_q - t2_q;
				vb_q <= t3_q - t4_q;
				if (t5_q >= t6_q) begin
					cmag_q <= t5_q - t6_q;
					neg_q  <= 1'b0;
				end else begin
					cmag_q <= t6_q - t5_q;
					neg_q  <= 1'b1;
				end
				res_q.correlation <= '0;
				res_q.pair_count  <= 9'(loaded_q);
				// Zero variance takes precedence over dropped pairs.
				res_q.status <= (t1_q == t2_q || t3_q == t4_q) ? ST_ZERO_VAR
					: (overflow_q ? ST_DROPPED : ST_OK);
			end
			S_PROD1: begin
				pab_q <= va_q * vb_q[LO_W-1:0];
				pcc_q <= cmag_q * cmag_q[LO_W-1:0];
			end
			S_PROD2: begin
				rem_q  <= DIV_W'(cc_full) << FRAC_SHIFT;
				dsh_q  <= DIV_W'(ab_full) << FRAC_SHIFT;
				quo_q  <= '0;
				dbit_q <= DBIT_W'(QUO_W - 1);
			end
			S_DIV: begin
				// One quotient bit per cycle: floor(2^30 C^2 / (A B)).
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				dsh_q  <= dsh_q >> 1;
				dbit_q <= dbit_q - DBIT_W'(1);
				root_q <= '0;
				rbit_q <= RBIT_W'(ROOT_W - 1);
			end
			S_SQRT: begin
				// One root bit per cycle; the last step also rounds.
				if (root_sq <= (2*ROOT_W)'(quo_q)) root_q <= root_try;
				rbit_q <= rbit_q - RBIT_W'(1);
				res_q.correlation <= neg_q ? -$signed(mag) : $signed(mag);
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

	// A set makes a single one-cycle strobe.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(done))
		else $error("result strobe lasted more than one cycle");

	// The closing transfer always starts the computation.
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && sample_pair.last_pair |=> busy)
		else $error("last pair did not start computation");

	// A result always counts at least one pair.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.pair_count != 9'd0)
		else $error("result with no pairs");

	// Zero variance gives a zero correlation.
	a_zero_var: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_ZERO_VAR |-> result.correlation == 16'sd0)
		else $error("zero variance with nonzero correlation");

	// The correlation stays within plus and minus one.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.correlation <= 16'sd16384 && result.correlation >= -16'sd16384))
		else $error("correlation out of range");

endmodule
